@@ rtl/cle_pkg.sv @@
// ----------------------------------------------------------------------------
// cle_pkg
// shared key codes and types for the console line editor
// ----------------------------------------------------------------------------
package cle_pkg;

   // control keys recognized by the line editor
   localparam logic [7:0] KEY_WAKE      = 8'h00;
   localparam logic [7:0] KEY_EOF       = 8'h04;
   localparam logic [7:0] KEY_BACKSPACE = 8'h08;
   localparam logic [7:0] KEY_NEWLINE   = 8'h0A;
   localparam logic [7:0] KEY_KILL      = 8'h15;

   typedef logic [7:0] byte_type;

endpackage

@@ rtl/cle_line_ram.sv @@
// ----------------------------------------------------------------------------
// cle_line_ram
// line store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module cle_line_ram
   import cle_pkg::*;
#(
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  byte_type      wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output byte_type      rd_data
);

   byte_type mem [DEPTH];
   byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/console_line_editor_core.sv @@
// ----------------------------------------------------------------------------
// console_line_editor_core
// console line discipline: collects keyboard bytes and emits committed lines
// ----------------------------------------------------------------------------
// A keyboard item is taken while the editor is idle. Items that do not commit
// the line keep it idle, and the next item can follow at once. A commit of n
// stored bytes streams them out of the line store at one byte per cycle while
// the output is not stalled (the store read is registered); an empty commit
// gives a single end-of-file item. The output register lets the next keyboard
// item be taken while the final byte of a line still waits to be taken.
// raw_mode is written through csr_wr_en / csr_wr_data; the user must write it
// only while the editor is idle, the block does not enforce it. The line store
// needs no clearing after reset: only entries below the fill count are read.
// ----------------------------------------------------------------------------
module console_line_editor_core
   import cle_pkg::*;
#(
   parameter int LINE_BYTES = 64
) (
   input  logic     clock,
   input  logic     reset,
   // configuration
   input  logic     csr_wr_en,
   input  logic     csr_wr_data,
   // keyboard items
   input  logic     req_valid,
   output logic     req_ready,
   input  byte_type req_key_byte,
   input  logic     req_more_pending,
   // committed line items
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output byte_type rsp_out_byte,
   output logic     rsp_last_of_line,
   output logic     rsp_empty_line
);

   // address width of the store and width of a count that can hold LINE_BYTES
   localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
   localparam int CW = $clog2(LINE_BYTES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(LINE_BYTES);

   typedef enum logic [1:0] {
      ST_IDLE,   // taking keyboard items
      ST_DRAIN,  // streaming stored bytes out
      ST_EMPTY   // end-of-file item waits for the output register
   } state_type;

   state_type     state_ff, state_in;
   logic          raw_mode_ff;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;    // next store entry to read
   logic          data_avail_ff, data_avail_in;  // store read data not yet used
   logic          data_last_ff, data_last_in;    // that data is the final byte
   logic          rsp_valid_ff, rsp_valid_in;
   byte_type      rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_empty_ff, rsp_empty_in;

   // per-item decode
   logic          accept;
   logic          do_store;
   logic          send;
   logic [CW-1:0] step_fill;
   logic          commit;

   // drain control
   logic          out_free;
   logic          load;
   logic          issue;
   byte_type      rd_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // editing rules for one keyboard item; fill is below LINE_BYTES here
   always_comb begin
      do_store  = 1'b0;
      send      = 1'b0;
      step_fill = fill_ff;
      if (req_key_byte == KEY_WAKE) begin
         // wake-up only flushes a non-empty line once input runs dry
         send = (fill_ff != '0) && !req_more_pending;
      end else if (raw_mode_ff) begin
         do_store = 1'b1;
         send     = !req_more_pending;
      end else begin
         case (req_key_byte)
            KEY_BACKSPACE: begin
               if (fill_ff != '0) begin
                  step_fill = fill_ff - 1'b1;
               end
            end
            KEY_KILL: begin
               step_fill = '0;
            end
            KEY_EOF: begin
               send = 1'b1;
            end
            KEY_NEWLINE: begin
               do_store = 1'b1;
               send     = 1'b1;
            end
            default: begin
               do_store = 1'b1;
            end
         endcase
      end
      if (do_store) begin
         step_fill = fill_ff + 1'b1;
      end
   end

   // a full store always commits
   assign commit = send || (step_fill == FULL_COUNT);

   // output register can take a new item this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;
   // move store read data into the output register
   assign load     = data_avail_ff && out_free;
   // read the next entry when its data will have a place to go
   assign issue    = (state_ff == ST_DRAIN) && (rd_idx_ff != fill_ff) &&
                     (!data_avail_ff || load);

   cle_line_ram #(
      .DEPTH (LINE_BYTES)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (accept && do_store),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (req_key_byte),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      rd_idx_in     = rd_idx_ff;
      data_avail_in = data_avail_ff;
      data_last_in  = data_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fill_in = step_fill;
               if (commit) begin
                  rd_idx_in = '0;
                  state_in  = (step_fill == '0) ? ST_EMPTY : ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (issue) begin
               rd_idx_in    = rd_idx_ff + 1'b1;
               data_last_in = (CW'(rd_idx_ff + 1'b1) == fill_ff);
            end
            data_avail_in = issue || (data_avail_ff && !load);
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rd_data;
               rsp_last_in  = data_last_ff;
               rsp_empty_in = 1'b0;
               if (data_last_ff) begin
                  // line fully handed over, store is free again
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               // end-of-file marker
               rsp_valid_in = 1'b1;
               rsp_byte_in  = '0;
               rsp_last_in  = 1'b1;
               rsp_empty_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         rd_idx_ff     <= '0;
         data_avail_ff <= 1'b0;
         data_last_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rd_idx_ff     <= rd_idx_in;
         data_avail_ff <= data_avail_in;
         data_last_ff  <= data_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         raw_mode_ff <= csr_wr_data;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_last_of_line = rsp_last_ff;
   assign rsp_empty_line   = rsp_empty_ff;

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the console line editor: a directed key script,
// then random typed lines in cooked and raw mode, against a line predictor
// ----------------------------------------------------------------------------
module tb;
   import cle_pkg::*;

   localparam int LINE_BYTES    = 64;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = LINE_BYTES + 8;
   localparam int STALL_LIMIT   = 5000;   // cycles with no item moving on either side
   localparam int PHASES        = 6;
   localparam int PHASE_KEYS    = 45;     // counted keys per random phase

   // one committed line item as seen on the rsp_ side
   typedef struct packed {
      byte_type out_byte;
      logic     last_of_line;
      logic     empty_line;
   } line_item_type;

   // what a row of the directed script does
   typedef enum logic [1:0] {
      ROW_KEY,    // one key item
      ROW_MODE,   // drain, then write raw_mode from key[0]
      ROW_FILL    // LINE_BYTES copies of key with more_pending set
   } row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      byte_type      key;
      logic          pend;
      logic          typed;   // expected item typed in below instead of predicted
      line_item_type want;
   } script_row_type;

   localparam line_item_type NO_ITEM = '{default: '0};
   localparam int SCRIPT_ROWS = 27;

   // directed key script, starting from reset in cooked mode
   localparam script_row_type KEY_SCRIPT [SCRIPT_ROWS] = '{
      '{ROW_KEY,  KEY_EOF,       1'b0, 1'b1, '{8'h00, 1'b1, 1'b1}},  // eof on empty line
      '{ROW_KEY,  8'h68,         1'b1, 1'b0, NO_ITEM},
      '{ROW_KEY,  8'hFF,         1'b1, 1'b0, NO_ITEM},
      '{ROW_KEY,  KEY_BACKSPACE, 1'b1, 1'b0, NO_ITEM},              // erase the 0xff
      '{ROW_KEY,  8'h69,         1'b0, 1'b0, NO_ITEM},
      '{ROW_KEY,  KEY_NEWLINE,   1'b0, 1'b0, NO_ITEM},              // h i newline
      '{ROW_KEY,  KEY_BACKSPACE, 1'b0, 1'b0, NO_ITEM},              // erase at empty
      '{ROW_KEY,  8'h78,         1'b1, 1'b0, NO_ITEM},
      '{ROW_KEY,  KEY_KILL,      1'b0, 1'b0, NO_ITEM},              // kill, no output
      '{ROW_KEY,  KEY_WAKE,      1'b0, 1'b0, NO_ITEM},              // wake on empty line
      '{ROW_KEY,  8'h01,         1'b0, 1'b0, NO_ITEM},
      '{ROW_KEY,  KEY_WAKE,      1'b1, 1'b0, NO_ITEM},              // wake, more pending
      '{ROW_KEY,  KEY_WAKE,      1'b0, 1'b1, '{8'h01, 1'b1, 1'b0}},  // wake sends line
      '{ROW_FILL, 8'h7E,         1'b1, 1'b0, NO_ITEM},              // full store, cooked
      '{ROW_KEY,  8'h80,         1'b0, 1'b0, NO_ITEM},
      '{ROW_KEY,  KEY_EOF,       1'b1, 1'b0, NO_ITEM},              // eof ignores pending
      '{ROW_MODE, 8'h01,         1'b0, 1'b0, NO_ITEM},
      '{ROW_KEY,  8'h41,         1'b0, 1'b1, '{8'h41, 1'b1, 1'b0}},  // raw, sent at once
      '{ROW_KEY,  KEY_BACKSPACE, 1'b1, 1'b0, NO_ITEM},              // control keys stored
      '{ROW_KEY,  KEY_KILL,      1'b1, 1'b0, NO_ITEM},
      '{ROW_KEY,  KEY_NEWLINE,   1'b1, 1'b0, NO_ITEM},
      '{ROW_KEY,  KEY_EOF,       1'b1, 1'b0, NO_ITEM},
      '{ROW_KEY,  KEY_WAKE,      1'b1, 1'b0, NO_ITEM},
      '{ROW_KEY,  8'hFF,         1'b0, 1'b0, NO_ITEM},
      '{ROW_FILL, 8'hFF,         1'b1, 1'b0, NO_ITEM},              // full store, raw
      '{ROW_KEY,  KEY_WAKE,      1'b0, 1'b0, NO_ITEM},              // raw wake, empty
      '{ROW_MODE, 8'h00,         1'b0, 1'b0, NO_ITEM}
   };

   // block ports, the inputs known from time zero
   logic     clock            = 1'b0;
   logic     reset            = 1'b1;
   logic     csr_wr_en        = 1'b0;
   logic     csr_wr_data      = 1'b0;
   logic     req_valid        = 1'b0;
   logic     req_ready;
   byte_type req_key_byte     = '0;
   logic     req_more_pending = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready        = 1'b0;
   byte_type rsp_out_byte;
   logic     rsp_last_of_line;
   logic     rsp_empty_line;

   // predictor state: own copy of the line store, fill count and mode
   byte_type      line_copy [LINE_BYTES];
   int            fill_now   = 0;
   bit            raw_now    = 1'b0;
   line_item_type commit_buf [LINE_BYTES];

   // expected line items, oldest first
   line_item_type due_chars [$];

   int mismatches  = 0;
   int counted_keys = 0;   // keys other than wake-up, for the random phases
   int idle_cycles = 0;
   bit calm        = 1'b0; // no idling on either side while set

   console_line_editor_core #(
      .LINE_BYTES (LINE_BYTES)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_byte     (req_key_byte),
      .req_more_pending (req_more_pending),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_line (rsp_last_of_line),
      .rsp_empty_line   (rsp_empty_line)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // append one byte to the predicted line, dropped when the store is full
   function automatic void stash_byte(byte_type key);
      if (fill_now < LINE_BYTES) begin
         line_copy[fill_now] = key;
         fill_now++;
      end
   endfunction

   // apply one key to the predicted line; fills commit_buf, returns item count
   function automatic int edit_key(byte_type key, bit pend);
      bit send;
      int n;
      send = 1'b0;
      n = 0;
      if (key == KEY_WAKE) begin
         // wake-up only flushes a non-empty line with nothing more waiting
         send = (fill_now > 0) && !pend;
      end else if (raw_now) begin
         stash_byte(key);
         send = !pend;
      end else begin
         case (key)
            KEY_BACKSPACE: begin
               if (fill_now > 0) fill_now--;
            end
            KEY_KILL: begin
               fill_now = 0;
            end
            KEY_EOF: begin
               send = 1'b1;
            end
            KEY_NEWLINE: begin
               stash_byte(key);
               send = 1'b1;
            end
            default: begin
               stash_byte(key);
            end
         endcase
      end
      // a full store always goes out
      if (send || fill_now >= LINE_BYTES) begin
         if (fill_now == 0) begin
            commit_buf[0] = '{8'h00, 1'b1, 1'b1};
            n = 1;
         end else begin
            for (int k = 0; k < fill_now; k++)
               commit_buf[k] = '{line_copy[k], (k == fill_now - 1), 1'b0};
            n = fill_now;
            fill_now = 0;
         end
      end
      return n;
   endfunction

   // offer one key item, wait for it to be taken, then queue its line items
   task automatic send_key(input byte_type key, input bit pend,
                           input bit use_typed, input line_item_type typed_item);
      int gap;
      int n;
      gap = pick_gap();
      // valid is lowered only when a gap follows, so it never drops and
      // rises in the same step
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_key_byte     <= key;
      req_more_pending <= pend;
      do @(posedge clock); while (!req_ready);
      n = edit_key(key, pend);
      if (use_typed) begin
         due_chars.push_back(typed_item);
      end else begin
         for (int k = 0; k < n; k++) due_chars.push_back(commit_buf[k]);
      end
      if (key != KEY_WAKE) counted_keys++;
   endtask

   // wait for the editor to go idle, then write raw_mode
   task automatic set_mode(input bit raw);
      req_valid <= 1'b0;
      while (due_chars.size() != 0) @(posedge clock);
      // a last non-committing key may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= raw;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      raw_now = raw;
   endtask

   // cooked line: printable and high bytes with some edits, ended by
   // newline or eof; sometimes empty, sometimes past a full store
   task automatic type_cooked_line();
      int len;
      int r;
      byte_type key;
      r = $urandom_range(0, 99);
      if (r < 5) len = 0;
      else if (r < 13) len = $urandom_range(LINE_BYTES - 3, LINE_BYTES + 5);
      else len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
         r = $urandom_range(0, 99);
         if (r < 70) key = byte_type'($urandom_range(8'h20, 8'h7E));
         else if (r < 86) key = byte_type'($urandom_range(8'h80, 8'hFF));
         else if (r < 94) key = KEY_BACKSPACE;
         else if (r < 96) key = KEY_KILL;
         else key = KEY_WAKE;
         send_key(key, 1'($urandom_range(0, 1)), 1'b0, NO_ITEM);
      end
      key = ($urandom_range(0, 9) < 7) ? KEY_NEWLINE : KEY_EOF;
      send_key(key, 1'($urandom_range(0, 1)), 1'b0, NO_ITEM);
   endtask

   // raw line: any bytes with more pending, ended by a byte or a wake-up
   // with nothing pending
   task automatic type_raw_line();
      int len;
      byte_type key;
      if ($urandom_range(0, 99) < 8) len = $urandom_range(LINE_BYTES - 3, LINE_BYTES + 5);
      else len = $urandom_range(0, 12);
      for (int k = 0; k < len; k++) begin
         key = ($urandom_range(0, 99) < 5) ? KEY_WAKE : byte_type'($urandom_range(1, 255));
         send_key(key, 1'b1, 1'b0, NO_ITEM);
      end
      key = ($urandom_range(0, 99) < 85) ? byte_type'($urandom_range(1, 255)) : KEY_WAKE;
      send_key(key, 1'b0, 1'b0, NO_ITEM);
   endtask

   // noise: a short burst of arbitrary keys and pending flags
   task automatic type_noise();
      int n;
      n = $urandom_range(2, 8);
      for (int k = 0; k < n; k++)
         send_key(byte_type'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'b0, NO_ITEM);
   endtask

   // stimulus
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed script
      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         case (KEY_SCRIPT[i].kind)
            ROW_KEY: begin
               send_key(KEY_SCRIPT[i].key, KEY_SCRIPT[i].pend,
                        KEY_SCRIPT[i].typed, KEY_SCRIPT[i].want);
            end
            ROW_MODE: begin
               set_mode(KEY_SCRIPT[i].key[0]);
            end
            ROW_FILL: begin
               for (int k = 0; k < LINE_BYTES; k++)
                  send_key(KEY_SCRIPT[i].key, KEY_SCRIPT[i].pend, 1'b0, NO_ITEM);
            end
            default: begin
            end
         endcase
      end

      // random phases; each mode change drains the editor first
      counted_keys = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         calm = (phase == 2);
         if (phase == 0) set_mode(1'b1);
         else if (phase == 1) set_mode(1'b0);
         else set_mode(1'($urandom_range(0, 1)));
         while (counted_keys < PHASE_KEYS * (phase + 1)) begin
            if ($urandom_range(0, 3) == 0) type_noise();
            else if (raw_now) type_raw_line();
            else type_cooked_line();
         end
      end
      calm = 1'b0;

      // drain, then give stray items a chance to show up
      req_valid <= 1'b0;
      while (due_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("console_line_editor_core: match");
      else $display("console_line_editor_core: mismatch");
      $finish;
   end

   // receiver: random stalls on rsp_ready
   int stall_left = 0;
   always @(posedge clock) begin
      int n;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         n = pick_gap();
         rsp_ready <= (n == 0);
         if (n > 0) stall_left = n - 1;
      end
   end

   // line item checker, against the oldest expectation
   always @(posedge clock) begin
      line_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_chars.size() == 0) begin
            $error("unexpected item: out_byte %h last_of_line %b empty_line %b",
                   rsp_out_byte, rsp_last_of_line, rsp_empty_line);
            mismatches++;
         end else begin
            want = due_chars.pop_front();
            if (rsp_empty_line !== want.empty_line) begin
               $error("empty_line: expected %b, got %b", want.empty_line, rsp_empty_line);
               mismatches++;
            end
            if (rsp_last_of_line !== want.last_of_line) begin
               $error("last_of_line: expected %b, got %b",
                      want.last_of_line, rsp_last_of_line);
               mismatches++;
            end
            // out_byte carries nothing on an end-of-file item
            if (!want.empty_line && rsp_out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_out_byte);
               mismatches++;
            end
         end
      end
   end

   // watchdog: too long with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("console_line_editor_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

@@ console_line_editor_core.f @@
rtl/cle_pkg.sv
rtl/cle_line_ram.sv
rtl/console_line_editor_core.sv
verif/tb.sv
